// ===== src/ctgsr_pkg.sv =====
// Shared types, gate codes and run flush table for the Clifford+T gate stream reducer.
// No dependencies.
package ctgsr_pkg;

  localparam int GateW = 4;
  localparam int MaxOut = 4;

  localparam logic [GateW-1:0] GATE_Z     = 4'd0;
  localparam logic [GateW-1:0] GATE_S     = 4'd1;
  localparam logic [GateW-1:0] GATE_SDG   = 4'd2;
  localparam logic [GateW-1:0] GATE_T     = 4'd3;
  localparam logic [GateW-1:0] GATE_TDG   = 4'd4;
  localparam logic [GateW-1:0] GATE_X     = 4'd5;
  localparam logic [GateW-1:0] GATE_H     = 4'd10;
  localparam logic [GateW-1:0] GATE_EMPTY = 4'd11;

  typedef enum logic [1:0] {
    BASIS_NONE = 2'd0,
    BASIS_Z    = 2'd1,
    BASIS_X    = 2'd2
  } basis_t;

  // results caused by one input item
  typedef struct packed {
    logic [2:0]                  count;
    logic [MaxOut-1:0][GateW-1:0] gates;
    logic                        last;
  } bundle_t;

  typedef struct packed {
    logic [1:0]       count;
    logic [GateW-1:0] g0;
    logic [GateW-1:0] g1;
  } flush_t;

  // rotation in eighths of a turn for a Z-family code 0..4
  function automatic logic [2:0] rot_of(input logic [2:0] idx);
    logic [2:0] r;
    unique case (idx)
      3'd0: r = 3'd4;
      3'd1: r = 3'd2;
      3'd2: r = 3'd6;
      3'd3: r = 3'd1;
      3'd4: r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic flush_t flush_run(input basis_t basis, input logic [2:0] sum);
    flush_t f;
    logic [GateW-1:0] off;
    off = (basis == BASIS_X) ? GATE_X : GATE_Z;
    f.count = 2'd0;
    f.g0 = '0;
    f.g1 = '0;
    if (basis != BASIS_NONE) begin
      unique case (sum)
        3'd1: begin f.count = 2'd1; f.g0 = GATE_T + off; end
        3'd2: begin f.count = 2'd1; f.g0 = GATE_S + off; end
        3'd3: begin f.count = 2'd2; f.g0 = GATE_TDG + off; f.g1 = GATE_Z + off; end
        3'd4: begin f.count = 2'd1; f.g0 = GATE_Z + off; end
        3'd5: begin f.count = 2'd2; f.g0 = GATE_T + off; f.g1 = GATE_Z + off; end
        3'd6: begin f.count = 2'd1; f.g0 = GATE_SDG + off; end
        3'd7: begin f.count = 2'd1; f.g0 = GATE_TDG + off; end
        default: f.count = 2'd0;
      endcase
    end
    return f;
  endfunction

endpackage

// ===== src/ctgsr_front.sv =====
// Front end: accepts gate codes, tracks Hadamard parity and the open run, and builds
// the bundle of results for each item. Depends on ctgsr_pkg.
module ctgsr_front import ctgsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [GateW-1:0] gate_code,
  input  logic             last_gate,
  input  logic             q_full,
  output logic             q_push,
  output bundle_t          q_data
);

  logic       parity;
  basis_t     run_basis;
  logic [2:0] run_sum;
  logic       parity_next;
  basis_t     run_basis_next;
  logic [2:0] run_sum_next;

  logic       gate_ok;
  logic       is_x;
  basis_t     in_basis;
  logic [2:0] rot;
  logic       parity_h;
  basis_t     nb;
  logic [2:0] ns;
  flush_t     f_old;
  flush_t     f_new;
  logic       split;
  bundle_t    b;
  logic [2:0] n;

  assign in_ready = !q_full;
  assign gate_ok  = gate_code < GATE_H;
  assign is_x     = gate_code >= GATE_X;
  assign in_basis = (is_x ^ parity) ? BASIS_X : BASIS_Z;
  assign rot      = rot_of(is_x ? 3'(gate_code - GATE_X) : gate_code[2:0]);
  assign parity_h = parity ^ (gate_code == GATE_H);
  assign split    = gate_ok && run_basis != BASIS_NONE && run_basis != in_basis;
  assign f_old    = flush_run(run_basis, run_sum);

  always_comb begin
    if (gate_ok && (run_basis == BASIS_NONE || split)) begin
      nb = in_basis;
      ns = rot;
    end else if (gate_ok) begin
      nb = run_basis;
      ns = 3'(run_sum + rot);
    end else begin
      nb = run_basis;
      ns = run_sum;
    end
  end

  assign f_new = flush_run(nb, ns);

  always_comb begin
    b = '0;
    n = 3'd0;
    if (split) begin
      if (f_old.count != 2'd0) b.gates[0] = f_old.g0;
      if (f_old.count == 2'd2) b.gates[1] = f_old.g1;
      n = {1'b0, f_old.count};
    end
    if (last_gate) begin
      if (f_new.count != 2'd0) begin
        b.gates[n[1:0]] = f_new.g0;
        n = n + 3'd1;
      end
      if (f_new.count == 2'd2) begin
        b.gates[n[1:0]] = f_new.g1;
        n = n + 3'd1;
      end
      if (parity_h) begin
        b.gates[n[1:0]] = GATE_H;
        n = n + 3'd1;
      end
      if (n == 3'd0) begin
        b.gates[0] = GATE_EMPTY;
        n = 3'd1;
      end
      b.last = 1'b1;
    end
    b.count = n;
  end

  assign q_data = b;
  assign q_push = in_valid && in_ready && b.count != 3'd0;

  always_comb begin
    if (last_gate) begin
      parity_next    = 1'b0;
      run_basis_next = BASIS_NONE;
      run_sum_next   = 3'd0;
    end else begin
      parity_next    = parity_h;
      run_basis_next = nb;
      run_sum_next   = ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      run_basis <= BASIS_NONE;
      run_sum   <= 3'd0;
    end else if (in_valid && in_ready) begin
      parity    <= parity_next;
      run_basis <= run_basis_next;
      run_sum   <= run_sum_next;
    end
  end

endmodule

// ===== src/ctgsr_queue.sv =====
// Short bundle queue between front and back ends.
// Depends on ctgsr_pkg.
module ctgsr_queue import ctgsr_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output bundle_t pop_data
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  bundle_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == CntFull;
  assign valid    = count != '0;
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + PtrW'(1);
      if (do_push && !do_pop) count <= count + CntW'(1);
      else if (do_pop && !do_push) count <= count - CntW'(1);
    end
  end

endmodule

// ===== src/ctgsr_back.sv =====
// Back end: holds one bundle in a register and sends its gates one transfer per cycle while out_ready is high.
// Depends on ctgsr_pkg.
module ctgsr_back import ctgsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bundle_t          q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [GateW-1:0] out_gate,
  output logic             out_last
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       done;

  assign at_end    = {1'b0, idx} == cur.count - 3'd1;
  assign done      = !cur_valid || (out_ready && at_end);
  assign q_pop     = done && q_valid;
  assign out_valid = cur_valid;
  assign out_gate  = cur.gates[idx];
  assign out_last  = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= q_valid;
      idx       <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ===== src/clifford_t_gate_stream_reducer.sv =====
// Clifford+T gate stream reducer, top level: front end, bundle queue, back end.
// On an idle block an item's bundle is registered in the queue and then in the back end
// before its first result is offered. Throughput: one item per cycle while the queue is not
// full; the queue of QueueDepth bundles lets the input run while results are being sent.
// Reset (rst, synchronous): clears parity, open run, queue and output valid.
// Depends on ctgsr_pkg, ctgsr_front, ctgsr_queue, ctgsr_back.
module clifford_t_gate_stream_reducer import ctgsr_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] gate_code, [7:4] zero
  input  logic       s_tlast,   // last_gate
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] out_gate, [7:4] zero
  output logic       m_tlast    // out_last
);

  logic             q_full;
  logic             q_push;
  bundle_t          q_in;
  logic             q_pop;
  logic             q_valid;
  bundle_t          q_out;
  logic [GateW-1:0] out_gate;

  ctgsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .gate_code (s_tdata[3:0]),
    .last_gate (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  ctgsr_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  ctgsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_gate  (out_gate),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_gate};

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_gate == GATE_EMPTY |-> m_tlast)
    else $error("empty marker without tlast");

  a_h_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_gate == GATE_H |-> m_tlast)
    else $error("H emitted before end of sequence");

  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_gate <= GATE_EMPTY)
    else $error("output gate code out of range");

  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full && q_in.count != 3'd0)
    else $error("queue push while full or empty bundle");
`endif

endmodule
